/* hw/rtl/positional_array_list_top_macros.svh */
// Assertion macros for the positional array list block.
// Used by the port checker; depends on nothing else.
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define PAL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define PAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hw/rtl/pal_pkg.sv */
// Shared types, codes and sizes for the positional array list block.
// No dependencies.
package pal_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int REQ_W  = 3;
  localparam int IPOS_W = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;

  // Internal position width, wide enough for the largest supported list.
  localparam int POS_W = 13;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_POS  = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Cell operations.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_REM  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
  } pal_ctl_t;

endpackage

/* hw/rtl/pal_cell.sv */
// One storage cell of the list chain: holds one entry word.
// Depends on pal_pkg.
module pal_cell #(
  parameter int IDX = 0,
  parameter int EW  = pal_pkg::ENTRY_WIDTH_DEF
) (
  input  logic              clk,
  input  pal_pkg::pal_ctl_t ctl,
  input  logic [EW-1:0]     new_word,
  input  logic [EW-1:0]     left_word,
  input  logic [EW-1:0]     right_word,
  output logic [EW-1:0]     data,
  output logic [EW-1:0]     sel_word
);

  localparam logic [pal_pkg::POS_W-1:0] MY_POS = pal_pkg::POS_W'(IDX);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      pal_pkg::CELL_INS: begin
        if (MY_POS > ctl.pos) begin
          data_nxt = left_word;
        end else if (MY_POS == ctl.pos) begin
          data_nxt = new_word;
        end
      end
      pal_pkg::CELL_REM: begin
        if (MY_POS >= ctl.pos) begin
          data_nxt = right_word;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  // Present the old word of the cell being removed, zero everywhere else.
  assign sel_word = ((ctl.op == pal_pkg::CELL_REM) && (MY_POS == ctl.pos)) ? data_r : '0;

endmodule

/* hw/rtl/pal_gather.sv */
// Two-level OR tree that collects the removed word from the cell chain.
// Depends on pal_pkg for default sizes.
module pal_gather #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int EW       = pal_pkg::ENTRY_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          capture,
  input  logic [EW-1:0] sel_word [CAPACITY],
  output logic [EW-1:0] removed
);

  localparam int GRP  = 16;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  logic [EW-1:0] grp_r   [NGRP];
  logic [EW-1:0] grp_nxt [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | sel_word[g * GRP + j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (capture) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    removed = '0;
    for (int g = 0; g < NGRP; g++) begin
      removed = removed | grp_r[g];
    end
  end

endmodule

/* hw/rtl/positional_array_list_top.sv */
// Top level of the positional array list block: request decode, cell chain,
// removed-word gather and result registers. Depends on pal_pkg, pal_cell and pal_gather.
//
// Ordered list of up to CAPACITY words, packed from position 0, built as a
// chain of cells that each hold one entry. Every good request (insert at head,
// tail or position; remove from head, tail or position) shifts the cells from
// its position onward by one place in the cycle the transaction is accepted,
// so the block sustains one transaction per cycle while results are not stalled.
// Each result passes through the gather stage, which registers the removed word
// from the cells in groups of sixteen, then the output register, which merges them.
// The next request sees the count and contents left by the previous one with
// no extra wait. Failed requests leave the list alone and report full, empty
// or out of range; removed_data is zero for anything but a good removal.
// Stored words start undefined; only positions below the count are ever read.
module positional_array_list_top #(
  parameter int CAPACITY    = pal_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pal_pkg::REQ_W-1:0]   in_req_type,
  input  logic [pal_pkg::IPOS_W-1:0]  in_position,
  input  logic [pal_pkg::DATA_W-1:0]  in_entry_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pal_pkg::STAT_W-1:0]  out_status,
  output logic [pal_pkg::DATA_W-1:0]  out_removed_data,
  output logic [pal_pkg::CNT_W-1:0]   out_entry_count
);

  localparam int EW  = ENTRY_WIDTH;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (EW > pal_pkg::DATA_W) ? EW : pal_pkg::DATA_W;
  localparam int XCW = (CW > pal_pkg::CNT_W) ? CW : pal_pkg::CNT_W;
  localparam int PW  = pal_pkg::POS_W;

  // List occupancy.
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Gather stage.
  logic                       s1_valid_r;
  logic [pal_pkg::STAT_W-1:0] s1_status_r;
  logic [pal_pkg::CNT_W-1:0]  s1_count_r;
  logic [pal_pkg::CNT_W-1:0]  s1_count_nxt;

  // Result registers.
  logic                       out_valid_r;
  logic [pal_pkg::STAT_W-1:0] out_status_r;
  logic [pal_pkg::DATA_W-1:0] out_removed_r;
  logic [pal_pkg::CNT_W-1:0]  out_count_r;

  logic in_fire;
  logic s1_adv;

  // Request decode.
  logic                       is_ins;
  logic                       is_rem;
  logic [PW-1:0]              tgt_pos;
  logic [PW-1:0]              cnt_ext;
  logic [pal_pkg::STAT_W-1:0] req_status;
  pal_pkg::pal_ctl_t          ctl;

  logic [XW-1:0] word_ext;
  logic [EW-1:0] new_word;
  logic [EW-1:0] removed_word;
  logic [XW-1:0] removed_ext;
  logic [XCW-1:0] count_wide;

  logic [EW-1:0] cell_data [CAPACITY];
  logic [EW-1:0] cell_sel  [CAPACITY];

  // Handshake: advance the gather stage when the result slot is free or
  // drained this cycle; take a new transaction when the gather stage is empty or moves.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign cnt_ext  = PW'(count_r);
  assign word_ext = XW'(in_entry_data);
  assign new_word = word_ext[EW-1:0];

  // Resolve the target position and check it against the occupancy.
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    tgt_pos = '0;
    case (in_req_type)
      pal_pkg::REQ_INS_HEAD: begin
        is_ins = 1'b1;
      end
      pal_pkg::REQ_INS_TAIL: begin
        is_ins  = 1'b1;
        tgt_pos = cnt_ext;
      end
      pal_pkg::REQ_INS_POS: begin
        is_ins  = 1'b1;
        tgt_pos = PW'(in_position);
      end
      pal_pkg::REQ_REM_HEAD: begin
        is_rem = 1'b1;
      end
      pal_pkg::REQ_REM_TAIL: begin
        is_rem  = 1'b1;
        tgt_pos = cnt_ext - PW'(1);
      end
      pal_pkg::REQ_REM_POS: begin
        is_rem  = 1'b1;
        tgt_pos = PW'(in_position);
      end
      default: begin
        is_ins = 1'b0;
        is_rem = 1'b0;
      end
    endcase

    req_status = pal_pkg::ST_OK;
    if (is_ins) begin
      // Full wins over a bad position.
      if (count_r >= CW'(CAPACITY)) begin
        req_status = pal_pkg::ST_FULL;
      end else if (tgt_pos > cnt_ext) begin
        req_status = pal_pkg::ST_RANGE;
      end
    end else if (is_rem) begin
      // Empty wins over a bad position.
      if (count_r == '0) begin
        req_status = pal_pkg::ST_EMPTY;
      end else if (tgt_pos >= cnt_ext) begin
        req_status = pal_pkg::ST_RANGE;
      end
    end
  end

  // Broadcast the shift command; hold every cell unless a good request fires.
  always_comb begin
    ctl.op  = pal_pkg::CELL_HOLD;
    ctl.pos = tgt_pos;
    count_nxt = count_r;
    if (in_fire && (req_status == pal_pkg::ST_OK)) begin
      if (is_ins) begin
        ctl.op    = pal_pkg::CELL_INS;
        count_nxt = count_r + CW'(1);
      end else if (is_rem) begin
        ctl.op    = pal_pkg::CELL_REM;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign count_wide   = XCW'(count_nxt);
  assign s1_count_nxt = count_wide[pal_pkg::CNT_W-1:0];

  // Cell chain: cells see their neighbors; the new word enters on the left of cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] left_w;
    logic [EW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    pal_cell #(
      .IDX (i),
      .EW  (EW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .data       (cell_data[i]),
      .sel_word   (cell_sel[i])
    );
  end

  // Collect the removed word; the group registers load with the transaction.
  pal_gather #(
    .CAPACITY (CAPACITY),
    .EW       (EW)
  ) u_gather (
    .clk      (clk),
    .capture  (in_fire),
    .sel_word (cell_sel),
    .removed  (removed_word)
  );

  assign removed_ext = XW'(removed_word);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= req_status;
      s1_count_r  <= s1_count_nxt;
    end
    if (s1_adv) begin
      out_status_r  <= s1_status_r;
      out_count_r   <= s1_count_r;
      out_removed_r <= removed_ext[pal_pkg::DATA_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_removed_data = out_removed_r;
  assign out_entry_count  = out_count_r;

endmodule

/* hw/rtl/pal_checker.sv */
// Port-level checker for the positional array list block, bound to the top.
// Depends on pal_pkg and positional_array_list_top_macros.svh.
`include "positional_array_list_top_macros.svh"

module pal_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [pal_pkg::REQ_W-1:0]   in_req_type,
  input logic [pal_pkg::IPOS_W-1:0]  in_position,
  input logic [pal_pkg::DATA_W-1:0]  in_entry_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pal_pkg::STAT_W-1:0]  out_status,
  input logic [pal_pkg::DATA_W-1:0]  out_removed_data,
  input logic [pal_pkg::CNT_W-1:0]   out_entry_count
);

  // Hold a waiting request unchanged until it is taken.
  `PAL_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_req_type) && $stable(in_position) && $stable(in_entry_data), "waiting request changed")

  // Hold a stalled result unchanged.
  `PAL_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_removed_data) && $stable(out_entry_count), "stalled result changed")

  // Drop any result during reset.
  `PAL_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid right after reset")

  // Report no removed word for a failed request.
  `PAL_ASSERT(a_fail_zero, clk, rst_n, out_valid && (out_status != pal_pkg::ST_OK) |-> out_removed_data == '0, "failed request returned data")

  // An empty report means the list stays empty.
  `PAL_ASSERT(a_empty_cnt, clk, rst_n, out_valid && (out_status == pal_pkg::ST_EMPTY) |-> out_entry_count == '0, "empty status with entries")

endmodule

bind positional_array_list_top pal_checker u_pal_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_req_type      (in_req_type),
  .in_position      (in_position),
  .in_entry_data    (in_entry_data),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_removed_data (out_removed_data),
  .out_entry_count  (out_entry_count)
);

/* sim/positional_array_list_top_tb.sv */
// Self-checking testbench for positional_array_list_top: drives list requests,
// predicts every result in a shadow list and compares it with the block's output.
// Depends on pal_pkg and positional_array_list_top.
module positional_array_list_top_tb;
  import pal_pkg::*;

  // Spare request codes; the block must leave the list alone for these.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int POS_MAX      = (1 << IPOS_W) - 1;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 36;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [IPOS_W-1:0] pos;
    logic [DATA_W-1:0] data;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] removed;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [IPOS_W-1:0]   in_position = '0;
  logic [DATA_W-1:0]   in_entry_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [DATA_W-1:0]   out_removed_data;
  logic [CNT_W-1:0]    out_entry_count;

  // Requests waiting to be offered, and results the block still owes us.
  list_req_t    request_backlog[$];
  list_result_t owed_results[$];

  // Shadow copy of the list, updated as each transaction is accepted.
  logic [DATA_W-1:0] shadow_words[LIST_DEPTH];
  logic [CNT_W-1:0]  shadow_len = '0;

  // Length the list will have once everything queued so far has gone through;
  // steers the generator toward full and empty lists.
  int planned_len = 0;

  int  in_idle_pct = IDLE_PCT;
  int  out_idle_pct = IDLE_PCT;
  int  error_count = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  bit  in_taken = 1'b0;
  int  random_sent = 0;

  positional_array_list_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_position      (in_position),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_data (out_removed_data),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return what the block must report.
  // Capacity is checked before position on inserts, emptiness before position
  // on removes; spare codes change nothing and report OK.
  function automatic list_result_t apply_list_request(input list_req_t r);
    list_result_t res;
    int           slot;
    res = '{status: ST_OK, removed: '0, count: '0};
    case (r.req)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (r.req == REQ_INS_HEAD) slot = 0;
        else if (r.req == REQ_INS_TAIL) slot = int'(shadow_len);
        else slot = int'(r.pos);
        if (int'(shadow_len) >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (slot > int'(shadow_len)) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = int'(shadow_len); i > slot; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[slot] = r.data;
          shadow_len++;
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (r.req == REQ_REM_HEAD) slot = 0;
        else if (r.req == REQ_REM_TAIL) slot = int'(shadow_len) - 1;
        else slot = int'(r.pos);
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (slot >= int'(shadow_len)) begin
          res.status = ST_RANGE;
        end else begin
          res.removed = shadow_words[slot];
          for (int i = slot; i + 1 < int'(shadow_len); i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    res.count = shadow_len;
    return res;
  endfunction

  // Queue a request for the driver and track where the list length is headed.
  task automatic push_request(input list_req_t r);
    request_backlog.push_back(r);
    case (r.req)
      REQ_INS_HEAD, REQ_INS_TAIL: if (planned_len < LIST_DEPTH) planned_len++;
      REQ_INS_POS: if (planned_len < LIST_DEPTH && int'(r.pos) <= planned_len) planned_len++;
      REQ_REM_HEAD, REQ_REM_TAIL: if (planned_len > 0) planned_len--;
      REQ_REM_POS: if (int'(r.pos) < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  // Mostly well-formed inserts or removes (ins_pct of 95 are inserts), with a
  // few raw requests of any code and position mixed in.
  task automatic random_request(input int ins_pct);
    int        roll;
    list_req_t r;
    roll   = $urandom_range(99);
    r.pos  = IPOS_W'($urandom_range(POS_MAX));
    r.data = $urandom;
    if (roll < 5) begin
      r.req = REQ_W'($urandom_range(REQ_SPARE_7));
    end else if (roll < 5 + ins_pct) begin
      case ($urandom_range(2))
        0: r.req = REQ_INS_HEAD;
        1: r.req = REQ_INS_TAIL;
        default: begin
          r.req = REQ_INS_POS;
          if ($urandom_range(9) != 0) r.pos = IPOS_W'($urandom_range(planned_len));
        end
      endcase
    end else begin
      case ($urandom_range(2))
        0: r.req = REQ_REM_HEAD;
        1: r.req = REQ_REM_TAIL;
        default: begin
          r.req = REQ_REM_POS;
          if (planned_len > 0 && $urandom_range(9) != 0)
            r.pos = IPOS_W'($urandom_range(planned_len - 1));
        end
      endcase
    end
    push_request(r);
    random_sent++;
  endtask

  // Block until every queued request is accepted and every result is back.
  // Check at the rising edge, where the driver never touches the backlog.
  task automatic wait_drained();
    while (request_backlog.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offer the next request at the falling edge. Hold valid and the
  // payload until the transaction is taken; idle at random between requests.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_req_type   <= request_backlog[0].req;
        in_position   <= request_backlog[0].pos;
        in_entry_data <= request_backlog[0].data;
        in_valid      <= 1'b1;
        void'(request_backlog.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and once, after enough results, hold off for a
  // long stretch so the block backs up and drops in_ready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && results_seen >= 150) begin
      out_ready  <= 1'b0;
      stall_left <= 200;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: predict on each accepted request, then check each accepted
  // result against the oldest prediction, field by field.
  always @(posedge clk) begin
    list_result_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        owed_results.push_back(apply_list_request('{req: in_req_type, pos: in_position,
                                                    data: in_entry_data}));
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding: status %0d removed %h count %0d",
                 out_status, out_removed_data, out_entry_count);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_removed_data !== want.removed) begin
            $error("removed_data: expected %h, actual %h", want.removed, out_removed_data);
            error_count++;
          end
          if (out_entry_count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, out_entry_count);
            error_count++;
          end
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: removes on an empty list (emptiness wins over a bad position),
    // inserts at every kind of position including append at the count,
    // out-of-range positions, spare codes, then remove back down to empty.
    push_request('{req: REQ_REM_HEAD, pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_TAIL, pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_POS,  pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_POS,  pos: 9'd511,   data: 32'hFFFF_FFFF});
    push_request('{req: REQ_INS_POS,  pos: 9'd1,     data: 32'hDEAD_BEEF});
    push_request('{req: REQ_INS_POS,  pos: 9'd0,     data: 32'h0000_0000});
    push_request('{req: REQ_INS_HEAD, pos: 9'd511,   data: 32'hFFFF_FFFF});
    push_request('{req: REQ_INS_TAIL, pos: 9'd256,   data: 32'h1234_5678});
    push_request('{req: REQ_INS_POS,  pos: 9'd3,     data: 32'hA5A5_A5A5});
    push_request('{req: REQ_INS_POS,  pos: 9'd2,     data: 32'h5A5A_5A5A});
    push_request('{req: REQ_INS_POS,  pos: 9'd511,   data: 32'h0BAD_0BAD});
    push_request('{req: REQ_INS_POS,  pos: 9'd6,     data: 32'h0BAD_0BAD});
    push_request('{req: REQ_SPARE_6,  pos: 9'd1,     data: 32'hFFFF_FFFF});
    push_request('{req: REQ_SPARE_7,  pos: 9'd511,   data: 32'hFFFF_FFFF});
    push_request('{req: REQ_REM_POS,  pos: 9'd5,     data: 32'h0});
    push_request('{req: REQ_REM_POS,  pos: 9'd256,   data: 32'h0});
    push_request('{req: REQ_REM_POS,  pos: 9'd2,     data: 32'h0});
    push_request('{req: REQ_REM_HEAD, pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_TAIL, pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_POS,  pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_TAIL, pos: 9'd0,     data: 32'h0});
    push_request('{req: REQ_REM_TAIL, pos: 9'd0,     data: 32'h0});
    // Pause the sender until every directed result is back.
    wait_drained();

    // Fill the list to capacity, then keep pushing so inserts hit a full list.
    // The long receiver stall lands in this phase while the backlog is deep.
    while (planned_len < LIST_DEPTH) random_request(92);
    repeat (12) random_request(80);
    wait_drained();

    // Run a stretch with no idling on either side.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (60) random_request(20);
    wait_drained();

    // Drain mostly with removals for the rest of the random budget.
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    while (random_sent < RANDOM_ITEMS) random_request(10);
    wait_drained();

    // Give the pipeline time to show any stray result.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* positional_array_list_top.f */
+incdir+hw/rtl
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_gather.sv
hw/rtl/positional_array_list_top.sv
hw/rtl/pal_checker.sv
sim/positional_array_list_top_tb.sv
